// ----- rtl/pre_pkg.sv -----
package pre_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CMP_W       = 7;

   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_TERM,
      CMD_RELEASE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RELEASE
   } seq_state_type;

   typedef enum logic {
      REG_MIN_LENGTH,
      REG_DANISH_LETTERS
   } reg_index_type;

   function automatic logic pre_is_printable(input logic [7:0] b, input logic danish);
      logic ok;
      ok = (b >= PRINT_LO) && (b <= PRINT_HI);
      case (b) inside
         8'h86, 8'h8F, 8'h91, 8'h92, 8'h9B, 8'h9D,
         8'hC5, 8'hC6, 8'hD8, 8'hE5, 8'hE6, 8'hF8: begin
            ok = ok | danish;
         end
         default: begin
            ok = ok;
         end
      endcase
      return ok;
   endfunction

endpackage

// ----- rtl/pre_front.sv -----
module pre_front
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32,
   parameter int CNT_W          = $clog2(MAX_MIN_LENGTH + 1),
   parameter int ADDR_W         = $clog2(MAX_MIN_LENGTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_file,
   input  logic [5:0]        min_length,
   input  logic              danish_letters,
   output logic              q_valid,
   output cmd_type           q_cmd,
   output logic [CNT_W-1:0]  q_count,
   input  logic              q_pop,
   input  logic              rel_done,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_next;
   logic             reporting_ff, reporting_in;
   logic             rel_pending_ff, rel_pending_in;
   logic             printable, accept, full_run;
   logic [CMP_W-1:0] eff_min;
   logic             push;
   cmd_type          push_cmd;

   cmd_type          q_cmd_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0] q_cnt_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [LEN_W-1:0] q_len_ff;
   logic             q_full;

   assign q_full    = q_len_ff == LEN_W'(QUEUE_DEPTH);
   assign q_valid   = q_len_ff != '0;
   assign q_cmd     = q_cmd_ff[rd_ptr_ff];
   assign q_count   = q_cnt_ff[rd_ptr_ff];

   // a new run may not overwrite the store while a release is still being read
   assign req_stall = q_full || (rel_pending_ff && !reporting_ff);
   assign accept    = req_valid && !req_stall;
   assign printable = pre_is_printable(req_data_byte, danish_letters);
   assign full_run  = cnt_ff == CNT_W'(MAX_MIN_LENGTH);
   assign cnt_next  = full_run ? cnt_ff : cnt_ff + 1'b1;
   assign wr_addr   = cnt_ff[ADDR_W-1:0];
   assign wr_data   = req_data_byte;

   always_comb begin
      eff_min = CMP_W'(min_length);
      if (eff_min == '0) begin
         eff_min = CMP_W'(1);
      end
      if (eff_min > CMP_W'(MAX_MIN_LENGTH)) begin
         eff_min = CMP_W'(MAX_MIN_LENGTH);
      end
   end

   always_comb begin
      push          = 1'b0;
      push_cmd.kind = CMD_PASS;
      push_cmd.data = req_data_byte;
      wr_en         = 1'b0;
      cnt_in        = cnt_ff;
      reporting_in  = reporting_ff;
      if (accept) begin
         if (req_end_of_file || !printable) begin
            push          = reporting_ff;
            push_cmd.kind = CMD_TERM;
            push_cmd.data = '0;
            cnt_in        = '0;
            reporting_in  = 1'b0;
         end else if (reporting_ff) begin
            push = 1'b1;
         end else begin
            wr_en  = !full_run;
            cnt_in = cnt_next;
            if (CMP_W'(cnt_next) >= eff_min) begin
               push          = 1'b1;
               push_cmd.kind = CMD_RELEASE;
               reporting_in  = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rel_pending_in = rel_pending_ff;
      if (push && push_cmd.kind == CMD_RELEASE) begin
         rel_pending_in = 1'b1;
      end else if (rel_done) begin
         rel_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         reporting_ff   <= 1'b0;
         rel_pending_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         q_len_ff       <= '0;
      end else begin
         cnt_ff         <= cnt_in;
         reporting_ff   <= reporting_in;
         rel_pending_ff <= rel_pending_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !q_pop) begin
            q_len_ff <= q_len_ff + 1'b1;
         end else if (!push && q_pop) begin
            q_len_ff <= q_len_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= push_cmd;
         q_cnt_ff[wr_ptr_ff] <= cnt_next;
      end
   end

endmodule

// ----- rtl/pre_back.sv -----
module pre_back
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32,
   parameter int CNT_W          = $clog2(MAX_MIN_LENGTH + 1),
   parameter int ADDR_W         = $clog2(MAX_MIN_LENGTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_cmd,
   input  logic [CNT_W-1:0]  q_count,
   output logic              q_pop,
   output logic              rel_done,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_string_done,
   output logic              rsp_last_of_run
);

   seq_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;

   logic [7:0]        held_mem [MAX_MIN_LENGTH];
   logic [7:0]        rd_ff;

   logic              s1_valid_ff, s1_from_mem_ff, s1_done_ff, s1_last_ff;
   logic [7:0]        s1_byte_ff;
   logic              rsp_valid_ff, rsp_done_ff, rsp_last_ff;
   logic [7:0]        rsp_byte_ff;

   logic              out_load, s1_free;
   logic              produce, from_mem, p_done, p_last;
   logic [7:0]        p_byte;
   logic [ADDR_W-1:0] rd_addr;
   logic              idx_last;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign s1_free  = !s1_valid_ff || out_load;
   assign idx_last = CMP_W'(idx_ff) + CMP_W'(1) == CMP_W'(rcount_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (q_valid && s1_free && q_cmd.kind == CMD_RELEASE
                && q_count != CNT_W'(1)) begin
               state_in = SEQ_RELEASE;
            end
         end
         SEQ_RELEASE: begin
            if (s1_free && idx_last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop     = 1'b0;
      produce   = 1'b0;
      from_mem  = 1'b0;
      p_byte    = q_cmd.data;
      p_done    = 1'b0;
      p_last    = 1'b1;
      rel_done  = 1'b0;
      rd_addr   = idx_ff;
      idx_in    = idx_ff;
      rcount_in = rcount_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (q_valid && s1_free) begin
               q_pop   = 1'b1;
               produce = 1'b1;
               case (q_cmd.kind)
                  CMD_TERM: begin
                     p_byte = '0;
                     p_done = 1'b1;
                  end
                  CMD_RELEASE: begin
                     from_mem  = 1'b1;
                     rd_addr   = '0;
                     p_last    = q_count == CNT_W'(1);
                     rel_done  = q_count == CNT_W'(1);
                     idx_in    = ADDR_W'(1);
                     rcount_in = q_count;
                  end
                  default: begin
                     p_done = 1'b0;
                  end
               endcase
            end
         end
         SEQ_RELEASE: begin
            if (s1_free) begin
               produce  = 1'b1;
               from_mem = 1'b1;
               p_last   = idx_last;
               rel_done = idx_last;
               idx_in   = idx_ff + 1'b1;
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (s1_free) begin
            s1_valid_ff <= produce;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      rcount_ff <= rcount_in;
      if (wr_en) begin
         held_mem[wr_addr] <= wr_data;
      end
      if (produce && from_mem) begin
         rd_ff <= held_mem[rd_addr];
      end
      if (produce) begin
         s1_from_mem_ff <= from_mem;
         s1_byte_ff     <= p_byte;
         s1_done_ff     <= p_done;
         s1_last_ff     <= p_last;
      end
      if (out_load && s1_valid_ff) begin
         rsp_byte_ff <= s1_from_mem_ff ? rd_ff : s1_byte_ff;
         rsp_done_ff <= s1_done_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_string_done = rsp_done_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ----- rtl/printable_run_extractor_top.sv -----
// Printable run extractor: scans a byte stream (one byte per req transfer) and
// reports runs of printable bytes (0x20..0x7E, plus the Danish DOS and Latin-1
// letters when enabled) that reach min_length. Bytes of a short run are kept in
// a store of MAX_MIN_LENGTH entries; the byte that reaches min_length releases
// them all in order, later bytes of the run pass straight through, and the end
// of a reported run gives one terminator with string_done set and out_byte 0.
// A new byte is taken every cycle unless the 4-entry command queue is full, or
// a reported run has closed while its release is still being read out of the
// store. Pass and terminator results leave at one per cycle while rsp_stall is
// low; a release of N held bytes is read out in order on the single read port
// of the store. A result passes through the command queue, the s1 register and
// the rsp output register. The user must write min_length and danish_letters
// over the csr port only while the block is idle; the block does not enforce it.
module printable_run_extractor_top
   import pre_pkg::*;
#(
   parameter int MAX_MIN_LENGTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_string_done,
   output logic        rsp_last_of_run,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W  = $clog2(MAX_MIN_LENGTH + 1);
   localparam int ADDR_W = $clog2(MAX_MIN_LENGTH);

   logic [5:0]        min_length_ff;
   logic              danish_ff;
   logic              csr_write;
   reg_index_type     csr_index;

   logic              q_valid, q_pop, rel_done;
   cmd_type           q_cmd;
   logic [CNT_W-1:0]  q_count;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= 6'd4;
         danish_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_LENGTH: begin
               min_length_ff <= csr_pwdata[5:0];
            end
            REG_DANISH_LETTERS: begin
               danish_ff <= csr_pwdata[0];
            end
            default: begin
               danish_ff <= danish_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MIN_LENGTH: begin
            csr_prdata = {26'd0, min_length_ff};
         end
         REG_DANISH_LETTERS: begin
            csr_prdata = {31'd0, danish_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   pre_front #(
      .MAX_MIN_LENGTH (MAX_MIN_LENGTH),
      .CNT_W          (CNT_W),
      .ADDR_W         (ADDR_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_file (req_end_of_file),
      .min_length      (min_length_ff),
      .danish_letters  (danish_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_count         (q_count),
      .q_pop           (q_pop),
      .rel_done        (rel_done),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data)
   );

   pre_back #(
      .MAX_MIN_LENGTH (MAX_MIN_LENGTH),
      .CNT_W          (CNT_W),
      .ADDR_W         (ADDR_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_count         (q_count),
      .q_pop           (q_pop),
      .rel_done        (rel_done),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_string_done (rsp_string_done),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- rtl/pre_checker.sv -----
module pre_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_string_done,
   input logic       rsp_last_of_run
);

   // terminator carries a zero byte and has rsp_last_of_run set
   a_term_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_out_byte == 8'h00 && rsp_last_of_run)
      else $error("terminator malformed");

   // data results are always printable, so never below space
   a_data_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_string_done |-> rsp_out_byte >= 8'h20)
      else $error("non-printable data result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_string_done) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind printable_run_extractor_top pre_checker u_pre_checker (.*);
